>>> hdl/osdac_pkg.sv
// ----------------------------------------------------------------------------
// osdac_pkg
// Types, constants and fixed-point helpers for the 2x oversampling DAC path.
// ----------------------------------------------------------------------------
package osdac_pkg;

    localparam int VAL_W  = 36;
    localparam int ACC_W  = 64;
    localparam int COEF_W = 25;
    localparam int HALF_W = 18;
    localparam int TAPS   = 8;
    localparam int ORDER  = 4;
    localparam int ERR_W  = 19;
    localparam int Q_W    = 12;
    localparam int FRAC_SHIFT = 20;
    localparam int SUM_SHIFT  = 4;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ERR_W-1:0]  t_err;
    typedef logic signed [Q_W-1:0]    t_q;

    localparam t_acc V_MAX = 64'sd34359738367;
    localparam t_acc V_MIN = -64'sd34359738368;

    localparam t_coef NS_B0 = 25'sd3022717;
    localparam t_coef NS_B2 = 25'sd1573508;

    localparam t_err ERR_RESET = 19'sd65536;
    localparam t_err ERR_LIM   = 19'sd131072;

    localparam logic [23:0] GAIN_RESET = 24'd1048576;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIR,
        ST_GAIN,
        ST_NSA,
        ST_NSB,
        ST_QUANT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic en;
        logic clr;
        logic hi;
    } t_mac_ctl;

    function automatic t_coef fir_coef(input logic [2:0] idx);
        t_coef c;
        case (idx)
            3'd0: c = -25'sd11822;
            3'd1: c = 25'sd40163;
            3'd2: c = -25'sd122289;
            3'd3: c = 25'sd547007;
            3'd4: c = 25'sd66594;
            3'd5: c = 25'sd9253;
            3'd6: c = -25'sd9663;
            default: c = -25'sd985;
        endcase
        return c;
    endfunction

    function automatic t_coef ns_a(input logic [1:0] idx);
        t_coef c;
        case (idx)
            2'd0: c = 25'sd1511359;
            2'd1: c = 25'sd1552850;
            2'd2: c = 25'sd786754;
            default: c = 25'sd189399;
        endcase
        return c;
    endfunction

    function automatic t_val sat36(input t_acc v);
        t_val r;
        if (v > V_MAX) begin
            r = V_MAX[VAL_W-1:0];
        end else if (v < V_MIN) begin
            r = V_MIN[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic t_val round_shift(input t_acc v, input int s);
        t_acc sum;
        sum = v + (t_acc'(1) <<< (s - 1));
        return sat36(sum >>> s);
    endfunction

endpackage

>>> hdl/osdac_mac.sv
// ----------------------------------------------------------------------------
// osdac_mac
// Shared multiply-accumulate unit, one half of a 36-bit operand per cycle.
// ----------------------------------------------------------------------------
module osdac_mac (
    input  logic               i_clk,
    input  osdac_pkg::t_mac_ctl i_ctl,
    input  osdac_pkg::t_val    i_operand,
    input  osdac_pkg::t_coef   i_coef,
    output osdac_pkg::t_acc    o_acc
);
    import osdac_pkg::*;

    logic signed [HALF_W:0]          part;
    logic signed [HALF_W+COEF_W:0]   prod;
    t_acc                            term;
    t_acc                            r_acc;
    t_acc                            n_acc;

    always_comb begin
        if (i_ctl.hi) begin
            part = $signed({i_operand[VAL_W-1], i_operand[VAL_W-1:HALF_W]});
        end else begin
            part = $signed({1'b0, i_operand[HALF_W-1:0]});
        end
        prod = part * i_coef;
        if (i_ctl.hi) begin
            term = t_acc'(prod) <<< HALF_W;
        end else begin
            term = t_acc'(prod);
        end
        if (i_ctl.clr) begin
            n_acc = term;
        end else begin
            n_acc = r_acc + term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> hdl/oversample_2x_noise_shaped_dac.sv
// ----------------------------------------------------------------------------
// oversample_2x_noise_shaped_dac
// 2x FIR interpolator with 4th-order error-feedback 12-bit quantizer.
// ----------------------------------------------------------------------------
// One input transfer yields one output transfer of two offset-binary codes.
// An item passes from input transfer to the output register through the
// single 19x25 multiply-accumulate unit, which handles every product in two
// halves: a FIR sum and a gain scale for each output code, then for each code
// a first and a second shaper pass and a quantizer pass, with a step after
// each sum to take the result, then the emit and an idle state to take the
// next item. The input is stalled while
// an item is in work; a finished result may wait on the output while the
// next item is taken, and the next emit waits until that result is taken.
module oversample_2x_noise_shaped_dac #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_gain_we,
    input  logic [23:0]            i_gain_wdata,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [3:0]             i_dither_first,
    input  logic [3:0]             i_dither_second,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [11:0]            o_out_first,
    output logic [11:0]            o_out_second
);
    import osdac_pkg::*;

    t_state           r_state, n_state;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_pass, n_pass;
    logic [23:0]      r_gain;
    logic signed [SAMPLE_BITS-1:0] r_dly [TAPS];
    t_val             r_taps [ORDER];
    t_err             r_err;
    t_val             r_x, r_x0, r_x1, r_tm1, r_w;
    logic [3:0]       r_dith0, r_dith1;
    t_q               r_q0, r_q1;
    logic             r_out_valid;
    logic [11:0]      r_out_first, r_out_second;

    t_mac_ctl         mac_ctl;
    t_val             operand;
    t_coef            coef;
    t_acc             acc;
    logic [2:0]       fir_idx;
    logic [2:0]       dly_sel;
    logic [1:0]       ns_idx;
    logic             in_xfer;
    logic             emit_go;

    logic [3:0]           dith;
    logic signed [6:0]    dval;
    logic signed [37:0]   qin;
    logic signed [37:0]   qmag;
    t_q                   q;
    logic signed [37:0]   err_full;
    t_err                 err_clamped;
    t_val                 xsel;

    osdac_mac u_mac (
        .i_clk     (i_clk),
        .i_ctl     (mac_ctl),
        .i_operand (operand),
        .i_coef    (coef),
        .o_acc     (acc)
    );

    assign in_xfer = i_valid && !o_stall;
    assign emit_go = !r_out_valid || !i_stall;
    assign fir_idx = r_cnt[3:1];
    assign dly_sel = r_pass ? fir_idx : ~fir_idx;
    assign ns_idx  = r_cnt[2:1];
    assign xsel    = r_pass ? r_x1 : r_x0;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 5'd1;
        n_pass  = r_pass;
        case (r_state)
            ST_IDLE: begin
                n_cnt  = '0;
                n_pass = 1'b0;
                if (i_valid) begin
                    n_state = ST_FIR;
                end
            end
            ST_FIR: begin
                if (r_cnt == 5'd16) begin
                    n_state = ST_GAIN;
                    n_cnt   = '0;
                end
            end
            ST_GAIN: begin
                if (r_cnt == 5'd2) begin
                    n_cnt = '0;
                    if (r_pass) begin
                        n_state = ST_NSA;
                        n_pass  = 1'b0;
                    end else begin
                        n_state = ST_FIR;
                        n_pass  = 1'b1;
                    end
                end
            end
            ST_NSA: begin
                if (r_cnt == 5'd8) begin
                    n_state = ST_NSB;
                    n_cnt   = '0;
                end
            end
            ST_NSB: begin
                if (r_cnt == 5'd4) begin
                    n_state = ST_QUANT;
                    n_cnt   = '0;
                end
            end
            ST_QUANT: begin
                n_cnt = '0;
                if (r_pass) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_NSA;
                    n_pass  = 1'b1;
                end
            end
            ST_EMIT: begin
                n_cnt = '0;
                if (emit_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mac_ctl = '0;
        operand = '0;
        coef    = '0;
        o_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_FIR: begin
                mac_ctl.en  = !r_cnt[4];
                mac_ctl.clr = (r_cnt == 5'd0);
                mac_ctl.hi  = r_cnt[0];
                operand     = VAL_W'(r_dly[dly_sel]);
                coef        = fir_coef(fir_idx);
            end
            ST_GAIN: begin
                mac_ctl.en  = !r_cnt[1];
                mac_ctl.clr = (r_cnt == 5'd0);
                mac_ctl.hi  = r_cnt[0];
                operand     = r_x;
                coef        = $signed({1'b0, r_gain});
            end
            ST_NSA: begin
                mac_ctl.en  = !r_cnt[3];
                mac_ctl.clr = (r_cnt == 5'd0);
                mac_ctl.hi  = r_cnt[0];
                operand     = r_taps[ns_idx];
                coef        = ns_a(ns_idx);
            end
            ST_NSB: begin
                mac_ctl.en  = !r_cnt[2];
                mac_ctl.clr = (r_cnt == 5'd0);
                mac_ctl.hi  = r_cnt[0];
                operand     = r_cnt[1] ? r_taps[1] : r_tm1;
                coef        = r_cnt[1] ? NS_B2 : NS_B0;
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    always_comb begin
        dith = r_pass ? r_dith1 : r_dith0;
        dval = $signed({2'b00, dith, 1'b0}) - 7'sd15;
        qin  = 38'(r_w) + (38'(dval) <<< 11);
        qmag = -qin;
        if (qin >= (38'sd2047 <<< 16)) begin
            q = 12'sd2047;
        end else if (qin <= -(38'sd2048 <<< 16)) begin
            q = -12'sd2048;
        end else if (!qin[37]) begin
            q = Q_W'((qin + 38'sd32768) >>> 16);
        end else begin
            q = -(Q_W'((qmag + 38'sd32768) >>> 16));
        end
        err_full = (38'(q) <<< 16) - 38'(r_w);
        if (err_full < -38'sd131072) begin
            err_clamped = -ERR_LIM;
        end else if (err_full > 38'sd131072) begin
            err_clamped = ERR_LIM;
        end else begin
            err_clamped = err_full[ERR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_gain      <= GAIN_RESET;
            r_err       <= ERR_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_dly[i] <= '0;
            end
            for (int i = 0; i < ORDER; i++) begin
                r_taps[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
            if (i_gain_we) begin
                r_gain <= i_gain_wdata;
            end
            if (in_xfer) begin
                r_dly[0] <= i_sample;
                for (int i = 1; i < TAPS; i++) begin
                    r_dly[i] <= r_dly[i-1];
                end
            end
            if (r_state == ST_NSB && r_cnt == 5'd4) begin
                r_taps[0] <= r_tm1;
                for (int i = 1; i < ORDER; i++) begin
                    r_taps[i] <= r_taps[i-1];
                end
            end
            if (r_state == ST_QUANT) begin
                r_err <= err_clamped;
            end
            if (r_state == ST_EMIT && emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dith0 <= i_dither_first;
            r_dith1 <= i_dither_second;
        end
        if (r_state == ST_FIR && r_cnt == 5'd16) begin
            r_x <= round_shift(acc, SUM_SHIFT);
        end
        if (r_state == ST_GAIN && r_cnt == 5'd2) begin
            if (r_pass) begin
                r_x1 <= round_shift(acc, FRAC_SHIFT);
            end else begin
                r_x0 <= round_shift(acc, FRAC_SHIFT);
            end
        end
        if (r_state == ST_NSA && r_cnt == 5'd8) begin
            r_tm1 <= sat36(t_acc'(r_err) - t_acc'(round_shift(acc, FRAC_SHIFT)));
        end
        if (r_state == ST_NSB && r_cnt == 5'd4) begin
            r_w <= sat36(t_acc'(xsel) - t_acc'(round_shift(acc, FRAC_SHIFT)));
        end
        if (r_state == ST_QUANT && !r_pass) begin
            r_q0 <= q;
        end
        if (r_state == ST_QUANT && r_pass) begin
            r_q1 <= q;
        end
        if (r_state == ST_EMIT && emit_go) begin
            r_out_first  <= {~r_q0[Q_W-1], r_q0[Q_W-2:0]};
            r_out_second <= {~r_q1[Q_W-1], r_q1[Q_W-2:0]};
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_first  = r_out_first;
    assign o_out_second = r_out_second;

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_FIR && r_cnt == 5'd0 && !r_pass))
        else $error("item transfer did not start the filter pass");

    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err <= ERR_LIM) && (r_err >= -ERR_LIM))
        else $error("shaper error out of clamp range");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("output valid raised outside emit");

endmodule

>>> verif/osdac_checker.sv
// ----------------------------------------------------------------------------
// osdac_checker
// Watches the sample and code channels of the oversampling DAC. It keeps its
// own copy of the delay line, the shaper state and the gain. It predicts both
// DAC codes for every input transfer and compares them with each output
// transfer, in order.
// ----------------------------------------------------------------------------
module osdac_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_gain_we,
    input  logic [23:0] i_gain_wdata,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [23:0] i_sample,
    input  logic [3:0]  i_dither_first,
    input  logic [3:0]  i_dither_second,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [11:0] i_out_first,
    input  logic [11:0] i_out_second,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0] first;
        logic [11:0] second;
    } t_codes;

    localparam longint Q_MAX = 64'sd34359738367;
    localparam longint Q_MIN = -64'sd34359738368;
    localparam longint A1 = 1511359;
    localparam longint A2 = 1552850;
    localparam longint A3 = 786754;
    localparam longint A4 = 189399;
    localparam longint B0 = 3022717;
    localparam longint B2 = 1573508;

    longint taps_fir [8] = '{-11822, 40163, -122289, 547007, 66594, 9253, -9663, -985};

    logic [23:0] gain_q;
    longint      hist [8];
    longint      shp [4];
    longint      err_q;
    t_codes      codes_due [$];

    function automatic longint clip36(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        longint t;
        t = v + (longint'(1) <<< (s - 1));
        return clip36(t >>> s);
    endfunction

    function automatic longint quant12(longint v);
        if (v >= (longint'(2047) <<< 16)) return 2047;
        if (v <= -(longint'(2048) <<< 16)) return -2048;
        if (v >= 0) return (v + 32768) >>> 16;
        return -((-v + 32768) >>> 16);
    endfunction

    function automatic logic [11:0] shape_code(longint x, logic [3:0] d);
        longint acc, tm1, fb, w, q, e, dith;
        acc = A1 * shp[0] + A2 * shp[1] + A3 * shp[2] + A4 * shp[3];
        tm1 = clip36(err_q - rnd_shift(acc, 20));
        fb = rnd_shift(B0 * tm1 + B2 * shp[1], 20);
        shp[3] = shp[2];
        shp[2] = shp[1];
        shp[1] = shp[0];
        shp[0] = tm1;
        w = clip36(x - fb);
        dith = (longint'(d) * 2 - 15) * 2048;
        q = quant12(w + dith);
        e = q * 65536 - w;
        if (e < -131072) e = -131072;
        if (e > 131072) e = 131072;
        err_q = e;
        return 12'(q + 2048);
    endfunction

    function automatic t_codes predict_codes(logic [23:0] s, logic [3:0] d0, logic [3:0] d1);
        longint fwd, mir, x0, x1;
        t_codes c;
        for (int i = 7; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = longint'(signed'(s));
        fwd = 0;
        mir = 0;
        for (int i = 0; i < 8; i++) begin
            fwd += taps_fir[i] * hist[7-i];
            mir += taps_fir[i] * hist[i];
        end
        x0 = rnd_shift(rnd_shift(fwd, 4) * longint'(gain_q), 20);
        x1 = rnd_shift(rnd_shift(mir, 4) * longint'(gain_q), 20);
        c.first  = shape_code(x0, d0);
        c.second = shape_code(x1, d1);
        return c;
    endfunction

    assign o_pending = codes_due.size();

    always @(posedge i_clk) begin
        t_codes got, want;
        if (!i_rst_n) begin
            gain_q <= 24'd1048576;
            for (int i = 0; i < 8; i++) hist[i] = 0;
            for (int i = 0; i < 4; i++) shp[i] = 0;
            err_q = 65536;
            o_fail_count = 0;
            codes_due.delete();
        end else begin
            if (i_gain_we) gain_q <= i_gain_wdata;
            if (i_valid && !i_stall_in)
                codes_due.push_back(predict_codes(i_sample, i_dither_first, i_dither_second));
            if (i_out_valid && !i_out_stall) begin
                got.first  = i_out_first;
                got.second = i_out_second;
                if (codes_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected transfer: first=%0d second=%0d",
                                 got.first, got.second);
                end else begin
                    want = codes_due.pop_front();
                    if (got != want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: first exp=%0d act=%0d, second exp=%0d act=%0d",
                                     want.first, got.first, want.second, got.second);
                    end
                end
            end
        end
    end

endmodule

>>> verif/tb_oversample_2x_noise_shaped_dac.sv
// ----------------------------------------------------------------------------
// tb_oversample_2x_noise_shaped_dac
// Drives PCM samples and dither codes through the oversampling DAC under
// several gain settings, with random idle bursts on both sides and a long
// output hold-off. The checker predicts and compares every code pair.
// ----------------------------------------------------------------------------
module tb_oversample_2x_noise_shaped_dac;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_gain_we;
    logic [23:0] i_gain_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [23:0] i_sample;
    logic [3:0]  i_dither_first;
    logic [3:0]  i_dither_second;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_out_first;
    logic [11:0] o_out_second;

    int fail_count;
    int pending;
    bit quiet;
    bit hold_req;

    oversample_2x_noise_shaped_dac #(.SAMPLE_BITS(24)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_gain_we(i_gain_we), .i_gain_wdata(i_gain_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_sample(i_sample), .i_dither_first(i_dither_first),
        .i_dither_second(i_dither_second),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_first(o_out_first), .o_out_second(o_out_second)
    );

    osdac_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_gain_we(i_gain_we), .i_gain_wdata(i_gain_wdata),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_sample(i_sample), .i_dither_first(i_dither_first),
        .i_dither_second(i_dither_second),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_first(o_out_first), .i_out_second(o_out_second),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (quiet || $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic send_sample(logic [23:0] s, logic [3:0] d0, logic [3:0] d1);
        i_valid <= 1'b1;
        i_sample <= s;
        i_dither_first <= d0;
        i_dither_second <= d1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic pause_input();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge i_clk);
    endtask

    task automatic drain_codes();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [23:0] g);
        i_gain_we <= 1'b1;
        i_gain_wdata <= g;
        @(posedge i_clk);
        i_gain_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3: return 24'($signed($urandom_range(0, 4095)) - 2048);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [23:0] gains [6];
        int n;
        gains = '{24'd0, 24'hFFFFFF, 24'd1048576, 24'd262144, 24'd4194304, 24'd0};
        gains[5] = 24'($urandom);
        quiet = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_gain_we = 1'b0;
        i_gain_wdata = '0;
        i_valid = 1'b0;
        i_sample = '0;
        i_dither_first = '0;
        i_dither_second = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(24'h7FFFFF, 4'd0, 4'd15);
        send_sample(24'h7FFFFF, 4'd15, 4'd0);
        send_sample(24'h800000, 4'd0, 4'd0);
        send_sample(24'h800000, 4'd15, 4'd15);
        send_sample(24'h000000, 4'd7, 4'd8);
        send_sample(24'hFFFFFF, 4'd8, 4'd7);
        for (int i = 0; i < 6; i++) send_sample(24'h7FFFFF, 4'd5, 4'd10);
        for (int i = 0; i < 6; i++) send_sample(24'h800000, 4'd10, 4'd5);
        for (int i = 0; i < 4; i++) send_sample(i[0] ? 24'h7FFFFF : 24'h800000, 4'd3, 4'd12);
        drain_codes();
        write_gain(24'hFFFFFF);
        send_sample(24'h7FFFFF, 4'd0, 4'd15);
        send_sample(24'h800000, 4'd15, 4'd0);
        send_sample(24'h000001, 4'd9, 4'd6);
        drain_codes();

        for (int p = 0; p < 6; p++) begin
            write_gain(gains[p]);
            n = (p == 5) ? 250 : 120;
            for (int i = 0; i < n; i++) begin
                if (p == 5 && i == 150) quiet = 1'b1;
                if (p == 2 && i == 20) hold_req = 1'b1;
                if (p == 3 && i == 60) drain_codes();
                send_sample(pick_sample(), 4'($urandom), 4'($urandom));
                if (!quiet && $urandom_range(0, 3) == 0) pause_input();
            end
            drain_codes();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
